[hw/rtl/sct_pkg.sv]
// Shared types, token kinds and byte classes for the source tokenizer.
`default_nettype none
package sct_pkg;

	typedef logic [3:0] kind_t;
	typedef logic [3:0] cls_t;

	localparam kind_t KIND_END     = 4'd0;
	localparam kind_t KIND_FUNC    = 4'd1;
	localparam kind_t KIND_IDENT   = 4'd2;
	localparam kind_t KIND_NUMBER  = 4'd3;
	localparam kind_t KIND_LINEEND = 4'd4;
	localparam kind_t KIND_LBRACE  = 4'd5;
	localparam kind_t KIND_RBRACE  = 4'd6;
	localparam kind_t KIND_LPAREN  = 4'd7;
	localparam kind_t KIND_RPAREN  = 4'd8;
	localparam kind_t KIND_PLUS    = 4'd9;
	localparam kind_t KIND_MINUS   = 4'd10;
	localparam kind_t KIND_STAR    = 4'd11;
	localparam kind_t KIND_SLASH   = 4'd12;
	localparam kind_t KIND_EQUALS  = 4'd13;
	localparam kind_t KIND_BSLASH  = 4'd14;
	localparam kind_t KIND_ERROR   = 4'd15;

	localparam cls_t CLS_SPACE = 4'd0;
	localparam cls_t CLS_CR    = 4'd1;
	localparam cls_t CLS_LF    = 4'd2;
	localparam cls_t CLS_ALPHA = 4'd3;
	localparam cls_t CLS_DIGIT = 4'd4;
	localparam cls_t CLS_DOT   = 4'd5;
	localparam cls_t CLS_BSL   = 4'd6;
	localparam cls_t CLS_HASH  = 4'd7;
	localparam cls_t CLS_PUNCT = 4'd8;
	localparam cls_t CLS_BAD   = 4'd9;

	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OPTR_W    = 2;

	localparam logic [7:0] IDENT_MAX = 8'd255;
	localparam logic [4:0] FRAC_MAX  = 5'd31;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		cls_t       cls;
		kind_t      kind;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] text_length;
		logic [4:0] frac_digits;
		logic [7:0] bad_char;
		logic       last;
	} tok_meta_t;

	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h66;
			2'd1:    c = 8'h75;
			2'd2:    c = 8'h6E;
			default: c = 8'h63;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/sct_if.sv]
// Handshake interfaces for the source byte and token channels.
`default_nettype none
interface sct_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface sct_tok_if #(
	parameter int MANTISSA_BITS = 48
);
	logic                     valid;
	logic                     ready;
	logic [3:0]               kind;
	logic [7:0]               text_length;
	logic [MANTISSA_BITS-1:0] mantissa;
	logic [4:0]               frac_digits;
	logic [7:0]               bad_char;
	logic                     last;

	modport source (output valid, output kind, output text_length, output mantissa,
		output frac_digits, output bad_char, output last, input ready);
	modport sink (input valid, input kind, input text_length, input mantissa,
		input frac_digits, input bad_char, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/sct_front.sv]
// Front end: takes source beats and registers each byte with its class.
`default_nettype none
module sct_front (
	input  wire            clk,
	input  wire            arst_n,
	sct_src_if.sink        src,
	output logic           valid_s1,
	output sct_pkg::item_t item_s1,
	input  wire            down_ready
);

	sct_pkg::cls_t  cls;
	sct_pkg::kind_t kind;

	always_comb begin
		cls  = sct_pkg::CLS_PUNCT;
		kind = sct_pkg::KIND_ERROR;
		case (src.ch) inside
			[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F: cls = sct_pkg::CLS_ALPHA;
			[8'h30:8'h39]:                       cls = sct_pkg::CLS_DIGIT;
			8'h2E:                               cls = sct_pkg::CLS_DOT;
			8'h20, 8'h09, 8'h0B, 8'h0C:          cls = sct_pkg::CLS_SPACE;
			8'h0D:                               cls = sct_pkg::CLS_CR;
			8'h0A:                               cls = sct_pkg::CLS_LF;
			8'h5C:                               cls = sct_pkg::CLS_BSL;
			8'h23:                               cls = sct_pkg::CLS_HASH;
			8'h7B:                               kind = sct_pkg::KIND_LBRACE;
			8'h7D:                               kind = sct_pkg::KIND_RBRACE;
			8'h28:                               kind = sct_pkg::KIND_LPAREN;
			8'h29:                               kind = sct_pkg::KIND_RPAREN;
			8'h2B:                               kind = sct_pkg::KIND_PLUS;
			8'h2D:                               kind = sct_pkg::KIND_MINUS;
			8'h2A:                               kind = sct_pkg::KIND_STAR;
			8'h2F:                               kind = sct_pkg::KIND_SLASH;
			8'h3D:                               kind = sct_pkg::KIND_EQUALS;
			default:                             cls = sct_pkg::CLS_BAD;
		endcase
	end

	assign src.ready = !valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			item_s1.ch   <= src.ch;
			item_s1.eoi  <= src.end_of_input;
			item_s1.cls  <= cls;
			item_s1.kind <= kind;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/sct_queue.sv]
// Short queue of classified bytes between front and back.
`default_nettype none
module sct_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push_valid,
	input  wire sct_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output sct_pkg::item_t pop_item,
	input  wire            pop
);

	sct_pkg::item_t             mem_q [sct_pkg::QDEPTH];
	logic [sct_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sct_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sct_pkg::QPTR_W:0]   cnt_q;
	logic                       do_push;
	logic                       do_pop;

	assign push_ready = cnt_q != (sct_pkg::QPTR_W+1)'(sct_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (sct_pkg::QPTR_W+1)'(do_push) - (sct_pkg::QPTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/sct_back.sv]
// Back end: token state machine and result queue feeding the token channel.
`default_nettype none
module sct_back #(
	parameter int MANTISSA_BITS = 48
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            head_valid,
	input  wire sct_pkg::item_t head,
	output logic           pop,
	sct_tok_if.source      tok
);

	localparam int MB = MANTISSA_BITS;
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_IDENT   = 3'd1;
	localparam logic [2:0] MODE_NUMBER  = 3'd2;
	localparam logic [2:0] MODE_BSLASH  = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;
	localparam logic [2:0] MODE_HALT    = 3'd5;

	logic [2:0]    mode_q, mode_d;
	logic [7:0]    len_q, len_d;
	logic          kwm_q, kwm_d;
	logic [MB-1:0] val_q, val_d;
	logic [4:0]    frac_q, frac_d;
	logic [1:0]    dots_q, dots_d;

	// token opened by the current byte
	logic                st_v;
	sct_pkg::tok_meta_t  st_meta;
	logic [2:0]          st_mode;
	logic [7:0]          st_len;
	logic                st_kwm;
	logic [MB-1:0]       st_val;
	logic [1:0]          st_dots;

	logic [7:0]          ia_len;
	logic                ia_kwm;
	logic [MB+3:0]       wide;
	logic                fits;
	logic [MB-1:0]       na_val;
	logic [4:0]          na_frac;
	logic [1:0]          na_dots;

	sct_pkg::tok_meta_t  id_meta, num_meta, bsl_meta, end_meta;
	logic                a_v, b_v;
	sct_pkg::tok_meta_t  a_meta, b_meta;
	logic [MB-1:0]       a_mant;
	logic                o0_v, o1_v;
	sct_pkg::tok_meta_t  o0_meta, o1_meta;
	logic [MB-1:0]       o0_mant;
	logic [1:0]          n_res;

	sct_pkg::tok_meta_t         meta_mem_q [sct_pkg::OUT_DEPTH];
	logic [MB-1:0]              mant_mem_q [sct_pkg::OUT_DEPTH];
	logic [sct_pkg::OPTR_W-1:0] owr_q, ord_q;
	logic [sct_pkg::OPTR_W:0]   ocnt_q;
	logic                       rd;

	assign rd  = tok.valid && tok.ready;
	assign pop = head_valid && (ocnt_q <= (sct_pkg::OPTR_W+1)'(sct_pkg::OUT_DEPTH - 2));

	always_comb begin
		id_meta = '0;
		id_meta.kind = (kwm_q && len_q == 8'd4) ? sct_pkg::KIND_FUNC : sct_pkg::KIND_IDENT;
		id_meta.text_length = len_q;
		num_meta = '0;
		num_meta.kind = sct_pkg::KIND_NUMBER;
		num_meta.frac_digits = frac_q;
		bsl_meta = '0;
		bsl_meta.kind = sct_pkg::KIND_BSLASH;
		end_meta = '0;
		end_meta.kind = sct_pkg::KIND_END;
	end

	// identifier extension
	always_comb begin
		ia_kwm = kwm_q;
		if (len_q < 8'd4) begin
			if (head.ch != sct_pkg::kw_char(len_q[1:0])) begin
				ia_kwm = 1'b0;
			end
		end else begin
			ia_kwm = 1'b0;
		end
		ia_len = (len_q == sct_pkg::IDENT_MAX) ? len_q : len_q + 8'd1;
	end

	// number extension: v*10 + d, overflow when the top bits are set
	always_comb begin
		wide = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1) + (MB+4)'(head.ch[3:0]);
		fits = wide[MB+3:MB] == 4'd0;
		na_val  = val_q;
		na_frac = frac_q;
		na_dots = dots_q;
		if (head.cls == sct_pkg::CLS_DOT) begin
			if (dots_q < 2'd2) begin
				na_dots = dots_q + 2'd1;
			end
		end else if (dots_q == 2'd0) begin
			na_val = fits ? wide[MB-1:0] : {MB{1'b1}};
		end else if (dots_q == 2'd1 && fits && frac_q < sct_pkg::FRAC_MAX) begin
			na_val  = wide[MB-1:0];
			na_frac = frac_q + 5'd1;
		end
	end

	// byte handled from idle
	always_comb begin
		st_v    = 1'b0;
		st_meta = '0;
		st_mode = MODE_IDLE;
		st_len  = '0;
		st_kwm  = 1'b1;
		st_val  = '0;
		st_dots = '0;
		case (head.cls)
			sct_pkg::CLS_ALPHA: begin
				st_mode = MODE_IDENT;
				st_len  = 8'd1;
				st_kwm  = head.ch == sct_pkg::kw_char(2'd0);
			end
			sct_pkg::CLS_DIGIT: begin
				st_mode = MODE_NUMBER;
				st_val  = MB'(head.ch[3:0]);
			end
			sct_pkg::CLS_DOT: begin
				st_mode = MODE_NUMBER;
				st_dots = 2'd1;
			end
			sct_pkg::CLS_LF: begin
				st_v         = 1'b1;
				st_meta.kind = sct_pkg::KIND_LINEEND;
			end
			sct_pkg::CLS_BSL: begin
				st_mode = MODE_BSLASH;
			end
			sct_pkg::CLS_HASH: begin
				st_mode = MODE_COMMENT;
			end
			sct_pkg::CLS_PUNCT: begin
				st_v         = 1'b1;
				st_meta.kind = head.kind;
			end
			sct_pkg::CLS_BAD: begin
				st_v             = 1'b1;
				st_meta.kind     = sct_pkg::KIND_ERROR;
				st_meta.bad_char = head.ch;
				st_mode          = MODE_HALT;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		len_d  = len_q;
		kwm_d  = kwm_q;
		val_d  = val_q;
		frac_d = frac_q;
		dots_d = dots_q;
		a_v    = 1'b0;
		a_meta = '0;
		a_mant = '0;
		b_v    = 1'b0;
		b_meta = '0;
		if (mode_q != MODE_HALT && head.eoi) begin
			case (mode_q)
				MODE_IDENT: begin
					a_v    = 1'b1;
					a_meta = id_meta;
				end
				MODE_NUMBER: begin
					a_v    = 1'b1;
					a_meta = num_meta;
					a_mant = val_q;
				end
				MODE_BSLASH: begin
					a_v    = 1'b1;
					a_meta = bsl_meta;
				end
				default: begin
				end
			endcase
			b_v    = 1'b1;
			b_meta = end_meta;
			mode_d = MODE_IDLE;
			len_d  = '0;
			kwm_d  = 1'b1;
			val_d  = '0;
			frac_d = '0;
			dots_d = '0;
		end else begin
			case (mode_q)
				MODE_HALT: begin
				end
				MODE_IDENT: begin
					if (head.cls == sct_pkg::CLS_ALPHA || head.cls == sct_pkg::CLS_DIGIT) begin
						len_d = ia_len;
						kwm_d = ia_kwm;
					end else begin
						a_v    = 1'b1;
						a_meta = id_meta;
					end
				end
				MODE_NUMBER: begin
					if (head.cls == sct_pkg::CLS_DIGIT || head.cls == sct_pkg::CLS_DOT) begin
						val_d  = na_val;
						frac_d = na_frac;
						dots_d = na_dots;
					end else begin
						a_v    = 1'b1;
						a_meta = num_meta;
						a_mant = val_q;
					end
				end
				MODE_BSLASH: begin
					if (head.cls == sct_pkg::CLS_LF) begin
						mode_d = MODE_IDLE;
					end else begin
						a_v    = 1'b1;
						a_meta = bsl_meta;
					end
				end
				MODE_COMMENT: begin
					if (head.cls == sct_pkg::CLS_LF || head.cls == sct_pkg::CLS_CR) begin
						mode_d = MODE_IDLE;
					end
				end
				default: begin
				end
			endcase
			// byte restarts from idle: idle itself, or a token that just closed
			if (mode_q == MODE_IDLE || a_v) begin
				b_v    = st_v;
				b_meta = st_meta;
				mode_d = st_mode;
				len_d  = st_len;
				kwm_d  = st_kwm;
				val_d  = st_val;
				frac_d = '0;
				dots_d = st_dots;
			end
		end
	end

	always_comb begin
		o0_v    = a_v || b_v;
		o1_v    = a_v && b_v;
		o0_meta = a_v ? a_meta : b_meta;
		o0_mant = a_v ? a_mant : '0;
		o1_meta = b_meta;
		o0_meta.last = !o1_v;
		o1_meta.last = 1'b1;
		n_res = {1'b0, o0_v} + {1'b0, o1_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			kwm_q  <= 1'b1;
			val_q  <= '0;
			frac_q <= '0;
			dots_q <= '0;
		end else if (pop) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			kwm_q  <= kwm_d;
			val_q  <= val_d;
			frac_q <= frac_d;
			dots_q <= dots_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (pop) begin
				owr_q <= owr_q + sct_pkg::OPTR_W'(n_res);
			end
			if (rd) begin
				ord_q <= ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (pop ? (sct_pkg::OPTR_W+1)'(n_res) : '0)
				- (sct_pkg::OPTR_W+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && o0_v) begin
			meta_mem_q[owr_q] <= o0_meta;
			mant_mem_q[owr_q] <= o0_mant;
		end
		if (pop && o1_v) begin
			meta_mem_q[owr_q + 1'b1] <= o1_meta;
			mant_mem_q[owr_q + 1'b1] <= '0;
		end
	end

	assign tok.valid       = ocnt_q != '0;
	assign tok.kind        = meta_mem_q[ord_q].kind;
	assign tok.text_length = meta_mem_q[ord_q].text_length;
	assign tok.frac_digits = meta_mem_q[ord_q].frac_digits;
	assign tok.bad_char    = meta_mem_q[ord_q].bad_char;
	assign tok.last        = meta_mem_q[ord_q].last;
	assign tok.mantissa    = mant_mem_q[ord_q];

endmodule
`default_nettype wire

[hw/rtl/source_char_tokenizer.sv]
// Top level of the streaming source tokenizer.
//
//  channel  side  beat payload
//  src      in    ch[7:0], end_of_input
//  tok      out   kind, text_length, mantissa, frac_digits, bad_char, last
//
// One source beat per cycle while the back end and tok side keep up; a byte that closes
// a token and starts another gives two token beats, which the tok side takes in turn.
// A source beat passes the front register, the byte queue and the back end, which
// writes the four-entry token queue, before its first token beat is valid.
// Back end takes a byte only with two free token slots; either side stalls alone.
// arst_n clears state to idle; after an error token every later beat is dropped.
`default_nettype none
module source_char_tokenizer #(
	parameter int MANTISSA_BITS = 48
) (
	input  wire       clk,
	input  wire       arst_n,
	sct_src_if.sink   src,
	sct_tok_if.source tok
);

	logic           f_valid;
	sct_pkg::item_t f_item;
	logic           q_ready;
	logic           h_valid;
	sct_pkg::item_t h_item;
	logic           h_pop;

	sct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.valid_s1   (f_valid),
		.item_s1    (f_item),
		.down_ready (q_ready)
	);

	sct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (q_ready),
		.pop_valid  (h_valid),
		.pop_item   (h_item),
		.pop        (h_pop)
	);

	sct_back #(
		.MANTISSA_BITS (MANTISSA_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (h_valid),
		.head       (h_item),
		.pop        (h_pop),
		.tok        (tok)
	);

endmodule
`default_nettype wire
